>>> design/cts_pkg.sv
`timescale 1ns / 1ps

package cts_pkg;

  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [1:0] OP_TX   = 2'd0;
  localparam logic [1:0] OP_RX   = 2'd1;
  localparam logic [1:0] OP_POLL = 2'd2;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_RECOVERING = 3'd1;
  localparam logic [2:0] ST_BAD_LEN    = 3'd2;
  localparam logic [2:0] ST_FIFO_FULL  = 3'd3;
  localparam logic [2:0] ST_REFUSED    = 3'd4;

  localparam logic [1:0] REG_POLL_PERIOD = 2'd0;
  localparam logic [1:0] REG_FAIL_THRESH = 2'd1;
  localparam logic [1:0] REG_BACKOFF_INI = 2'd2;
  localparam logic [1:0] REG_BACKOFF_MAX = 2'd3;

  localparam logic [15:0] POLL_PERIOD_RST = 16'd5;
  localparam logic [7:0]  FAIL_THRESH_RST = 8'd3;
  localparam logic [15:0] BACKOFF_INI_RST = 16'd250;
  localparam logic [15:0] BACKOFF_MAX_RST = 16'd4000;

  typedef struct packed {
    logic [15:0] poll_period;
    logic [7:0]  fail_thresh;
    logic [15:0] backoff_ini;
    logic [15:0] backoff_max;
  } cfg_t;

  // Classified event as it waits between the front and back parts.
  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] now_ms;
    logic        len_bad;
    logic [3:0]  dlc;
    logic [2:0]  tx_status;
    logic        fifo_empty_slots;
    logic        bus_off;
    logic        clean;
  } cmd_t;

  // DLC for a payload length; bit 4 set means the length has no code.
  function automatic logic [4:0] len_code(input logic [6:0] len);
    logic [4:0] code;
    if (len <= 7'd8) begin
      code = len[4:0];
    end else begin
      case (len)
        7'd12:   code = 5'd9;
        7'd16:   code = 5'd10;
        7'd20:   code = 5'd11;
        7'd24:   code = 5'd12;
        7'd32:   code = 5'd13;
        7'd48:   code = 5'd14;
        7'd64:   code = 5'd15;
        default: code = 5'd16;
      endcase
    end
    return code;
  endfunction

endpackage

>>> design/cts_if.sv
`timescale 1ns / 1ps

interface cts_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] opcode;
  logic [31:0] now_ms;
  logic [6:0] payload_len;
  logic       fd_frame;
  logic [5:0] fifo_free;
  logic       queue_accepted;
  logic       bus_off_flag;
  logic [1:0] activity;
  logic       passive_flag;
  logic       warning_flag;
  logic [7:0] tx_err_cnt;
  logic [6:0] rx_err_cnt;

  modport source (
    output valid, opcode, now_ms, payload_len, fd_frame, fifo_free, queue_accepted,
           bus_off_flag, activity, passive_flag, warning_flag, tx_err_cnt, rx_err_cnt,
    input  ready
  );
  modport sink (
    input  valid, opcode, now_ms, payload_len, fd_frame, fifo_free, queue_accepted,
           bus_off_flag, activity, passive_flag, warning_flag, tx_err_cnt, rx_err_cnt,
    output ready
  );
endinterface

interface cts_rsp_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [3:0]  dlc_code;
  logic        recovered;
  logic        abort_pending;
  logic        clear_init;
  logic        tx_ready;
  logic [15:0] fail_streak;
  logic [15:0] recoveries;
  logic [15:0] hold_off_ms;

  modport source (
    output valid, status, dlc_code, recovered, abort_pending, clear_init, tx_ready,
           fail_streak, recoveries, hold_off_ms,
    input  ready
  );
  modport sink (
    input  valid, status, dlc_code, recovered, abort_pending, clear_init, tx_ready,
           fail_streak, recoveries, hold_off_ms,
    output ready
  );
endinterface

>>> design/cts_front.sv
`timescale 1ns / 1ps

module cts_front (
  cts_req_if.sink       req,
  output logic          push_valid,
  input  logic          push_ready,
  output cts_pkg::cmd_t push_cmd
);

  logic [4:0] code;

  assign code       = cts_pkg::len_code(req.payload_len);
  assign req.ready  = push_ready;
  assign push_valid = req.valid;

  always_comb begin
    push_cmd.opcode  = req.opcode;
    push_cmd.now_ms  = req.now_ms;
    push_cmd.len_bad = code[4] || (!req.fd_frame && (req.payload_len > 7'd8));
    push_cmd.dlc     = code[3:0];
    if (req.fifo_free == 6'd0) begin
      push_cmd.tx_status = cts_pkg::ST_FIFO_FULL;
    end else if (!req.queue_accepted) begin
      push_cmd.tx_status = cts_pkg::ST_REFUSED;
    end else begin
      push_cmd.tx_status = cts_pkg::ST_OK;
    end
    push_cmd.fifo_empty_slots = (req.fifo_free == 6'd0);
    push_cmd.bus_off = req.bus_off_flag;
    push_cmd.clean   = !req.bus_off_flag && (req.activity != 2'd0) && !req.passive_flag &&
                       !req.warning_flag && (req.tx_err_cnt == 8'd0) &&
                       (req.rx_err_cnt == 7'd0);
  end

endmodule

>>> design/cts_queue.sv
`timescale 1ns / 1ps

module cts_queue #(
  parameter int DEPTH = cts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push_valid,
  output logic          push_ready,
  input  cts_pkg::cmd_t push_cmd,
  output logic          pop_valid,
  input  logic          pop_ready,
  output cts_pkg::cmd_t pop_cmd
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cts_pkg::cmd_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

>>> design/cts_back.sv
`timescale 1ns / 1ps

module cts_back (
  input  logic          clk,
  input  logic          rst,
  input  cts_pkg::cfg_t cfg,
  input  logic          pop_valid,
  output logic          pop_ready,
  input  cts_pkg::cmd_t pop_cmd,
  cts_rsp_if.source     rsp
);

  logic [15:0] streak;
  logic [15:0] streak_next;
  logic [15:0] rec_total;
  logic [15:0] rec_total_next;
  logic        in_rec;
  logic        in_rec_next;
  logic        rec_bus_off;
  logic        rec_bus_off_next;
  logic [31:0] deadline;
  logic [31:0] deadline_next;
  logic [15:0] backoff;
  logic [15:0] backoff_next;
  logic [31:0] last_poll;
  logic [31:0] last_poll_next;

  logic [2:0]  status;
  logic [3:0]  dlc;
  logic        recovered;
  logic        abort_cmd;
  logic        clear_cmd;
  logic        go;
  logic        enter;
  logic [31:0] elapsed;
  logic [31:0] since_deadline;
  logic [15:0] hold;
  logic [16:0] doubled;

  assign pop_ready = !rsp.valid || rsp.ready;
  assign go        = pop_valid && pop_ready;

  assign elapsed        = pop_cmd.now_ms - last_poll;
  assign since_deadline = pop_cmd.now_ms - deadline;
  assign hold           = (backoff < cfg.backoff_ini) ? cfg.backoff_ini : backoff;
  assign doubled        = {hold, 1'b0};

  always_comb begin
    streak_next      = streak;
    rec_total_next   = rec_total;
    in_rec_next      = in_rec;
    rec_bus_off_next = rec_bus_off;
    deadline_next    = deadline;
    backoff_next     = backoff;
    last_poll_next   = last_poll;
    status           = cts_pkg::ST_OK;
    dlc              = 4'd0;
    recovered        = 1'b0;
    abort_cmd        = 1'b0;
    clear_cmd        = 1'b0;
    enter            = 1'b0;
    case (pop_cmd.opcode)
      cts_pkg::OP_TX: begin
        if (in_rec) begin
          status = cts_pkg::ST_RECOVERING;
        end else if (pop_cmd.len_bad) begin
          status = cts_pkg::ST_BAD_LEN;
        end else begin
          dlc    = pop_cmd.dlc;
          status = pop_cmd.tx_status;
          if (pop_cmd.tx_status == cts_pkg::ST_OK) begin
            streak_next = 16'd0;
          end else if (streak != 16'hFFFF) begin
            streak_next = streak + 16'd1;
          end
        end
      end
      cts_pkg::OP_RX: begin
        backoff_next = cfg.backoff_ini;
        streak_next  = 16'd0;
      end
      cts_pkg::OP_POLL: begin
        if (elapsed >= {16'd0, cfg.poll_period}) begin
          last_poll_next = pop_cmd.now_ms;
          if (in_rec) begin
            if ((!rec_bus_off || pop_cmd.clean) && !since_deadline[31]) begin
              in_rec_next      = 1'b0;
              rec_bus_off_next = 1'b0;
              deadline_next    = 32'd0;
              streak_next      = 16'd0;
              if (rec_total != 16'hFFFF) begin
                rec_total_next = rec_total + 16'd1;
              end
              recovered = 1'b1;
            end
          end else if (pop_cmd.bus_off) begin
            enter     = 1'b1;
            abort_cmd = 1'b1;
            clear_cmd = 1'b1;
          end else if (pop_cmd.fifo_empty_slots && (streak >= {8'd0, cfg.fail_thresh})) begin
            enter     = 1'b1;
            abort_cmd = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    if (enter) begin
      in_rec_next      = 1'b1;
      rec_bus_off_next = clear_cmd;
      deadline_next    = pop_cmd.now_ms + {16'd0, hold};
      if (hold < cfg.backoff_max) begin
        backoff_next = (doubled > {1'b0, cfg.backoff_max}) ? cfg.backoff_max : doubled[15:0];
      end else begin
        backoff_next = hold;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      streak      <= 16'd0;
      rec_total   <= 16'd0;
      in_rec      <= 1'b0;
      rec_bus_off <= 1'b0;
      deadline    <= 32'd0;
      backoff     <= cts_pkg::BACKOFF_INI_RST;
      last_poll   <= 32'd0;
      rsp.valid   <= 1'b0;
    end else begin
      if (go) begin
        streak      <= streak_next;
        rec_total   <= rec_total_next;
        in_rec      <= in_rec_next;
        rec_bus_off <= rec_bus_off_next;
        deadline    <= deadline_next;
        backoff     <= backoff_next;
        last_poll   <= last_poll_next;
        rsp.valid   <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rsp.status        <= status;
      rsp.dlc_code      <= dlc;
      rsp.recovered     <= recovered;
      rsp.abort_pending <= abort_cmd;
      rsp.clear_init    <= clear_cmd;
      rsp.tx_ready      <= !in_rec_next;
      rsp.fail_streak   <= streak_next;
      rsp.recoveries    <= rec_total_next;
      rsp.hold_off_ms   <= backoff_next;
    end
  end

endmodule

>>> design/can_tx_recovery_supervisor.sv
`timescale 1ns / 1ps
// Channel   Port  Direction  Carries
// -------   ----  ---------  ---------------------------------------------
// events    req   in         opcode, tick, frame length and format, status
// results   rsp   out        status, DLC, recovery commands, counters
// config    cfg   in         cfg_we, cfg_index, cfg_data
//
// One item per cycle sustained while rsp.ready holds; a taken item passes the
// combinational classifier into the command queue, then into the output register.
// The back part registers its state update together with the item's result.
// Synchronous reset clears all state and the queue; hold-off returns to 250 ms.
// A stalled result register stops the back part; the queue then absorbs
// QUEUE_DEPTH items before req.ready falls.

module can_tx_recovery_supervisor #(
  parameter int QUEUE_DEPTH = cts_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  cts_req_if.sink     req,
  cts_rsp_if.source   rsp,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  cts_pkg::cfg_t cfg;
  cts_pkg::cmd_t push_cmd;
  cts_pkg::cmd_t pop_cmd;
  logic          push_valid;
  logic          push_ready;
  logic          pop_valid;
  logic          pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.poll_period <= cts_pkg::POLL_PERIOD_RST;
      cfg.fail_thresh <= cts_pkg::FAIL_THRESH_RST;
      cfg.backoff_ini <= cts_pkg::BACKOFF_INI_RST;
      cfg.backoff_max <= cts_pkg::BACKOFF_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        cts_pkg::REG_POLL_PERIOD: cfg.poll_period <= cfg_data;
        cts_pkg::REG_FAIL_THRESH: cfg.fail_thresh <= cfg_data[7:0];
        cts_pkg::REG_BACKOFF_INI: cfg.backoff_ini <= cfg_data;
        cts_pkg::REG_BACKOFF_MAX: cfg.backoff_max <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  cts_front u_front (
    .req        (req),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  cts_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  cts_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .rsp       (rsp)
  );

`ifndef SYNTHESIS
  a_clear_needs_abort: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.clear_init |-> rsp.abort_pending)
    else $error("clear_init without abort_pending");

  a_enter_or_finish: assert property (@(posedge clk) disable iff (rst)
    rsp.valid |-> !(rsp.recovered && rsp.abort_pending))
    else $error("recovery finished and started by one item");

  a_recovering_not_ready: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && (rsp.status == cts_pkg::ST_RECOVERING) |-> !rsp.tx_ready)
    else $error("recovery status reported while ready");

  a_abort_not_ready: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.abort_pending |-> !rsp.tx_ready && (rsp.status == cts_pkg::ST_OK))
    else $error("recovery entry reported as ready");
`endif

endmodule

>>> sim/can_tx_recovery_supervisor_tb.sv
`timescale 1ns / 1ps

module can_tx_recovery_supervisor_tb;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 300000;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] now_ms;
    logic [6:0]  payload_len;
    logic        fd_frame;
    logic [5:0]  fifo_free;
    logic        queue_accepted;
    logic        bus_off_flag;
    logic [1:0]  activity;
    logic        passive_flag;
    logic        warning_flag;
    logic [7:0]  tx_err_cnt;
    logic [6:0]  rx_err_cnt;
  } event_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  dlc_code;
    logic        recovered;
    logic        abort_pending;
    logic        clear_init;
    logic        tx_ready;
    logic [15:0] fail_streak;
    logic [15:0] recoveries;
    logic [15:0] hold_off_ms;
  } outcome_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  cts_req_if req_ch ();
  cts_rsp_if rsp_ch ();

  can_tx_recovery_supervisor u_top (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Register copies used by the predictor.
  logic [15:0] poll_gap_ms;
  logic [7:0]  fail_limit;
  logic [15:0] hold_base_ms;
  logic [15:0] hold_cap_ms;

  // Supervisor state as predicted.
  logic [15:0] streak;
  logic [31:0] fail_count;
  logic [15:0] recov_count;
  logic        recovering;
  logic        recov_bus_off;
  logic [31:0] resume_at;
  logic [15:0] hold_off;
  logic [31:0] last_poll_ms;
  logic [2:0]  last_result;

  event_t   pending_events[$];
  outcome_t expected_outcomes[$];
  event_t   offered;
  outcome_t got;
  outcome_t want;

  int unsigned src_idle_pct;
  int unsigned snk_stall_pct;
  logic        hold_go;
  logic        holding;
  logic [31:0] ms_clock;
  int unsigned cycle_count;
  int unsigned mismatches;
  int unsigned n_tx, n_rx, n_poll, n_unused;
  int unsigned n_started, n_finished, n_settings;

  function automatic logic [4:0] dlc_for_len(logic [6:0] len);
    logic [4:0] code;
    if (len <= 7'd8) begin
      code = len[4:0];
    end else begin
      case (len)
        7'd12:   code = 5'd9;
        7'd16:   code = 5'd10;
        7'd20:   code = 5'd11;
        7'd24:   code = 5'd12;
        7'd32:   code = 5'd13;
        7'd48:   code = 5'd14;
        7'd64:   code = 5'd15;
        default: code = 5'd16;
      endcase
    end
    return code;
  endfunction

  function automatic void start_recovery(logic [31:0] now, logic for_bus_off);
    logic [15:0] b;
    logic [16:0] dbl;
    b = hold_off;
    recovering = 1'b1;
    recov_bus_off = for_bus_off;
    if (b < hold_base_ms) b = hold_base_ms;
    resume_at = now + {16'd0, b};
    if (b < hold_cap_ms) begin
      dbl = {b, 1'b0};
      if (dbl > {1'b0, hold_cap_ms}) dbl = {1'b0, hold_cap_ms};
      b = dbl[15:0];
    end
    hold_off = b;
    last_result = cts_pkg::ST_RECOVERING;
  endfunction

  function automatic outcome_t predict_outcome(event_t ev);
    outcome_t o;
    logic [4:0] code;
    logic [31:0] since;
    logic [31:0] past;
    logic clean;
    o = '0;
    code = dlc_for_len(ev.payload_len);
    case (ev.opcode)
      cts_pkg::OP_TX: begin
        if (recovering) begin
          o.status = cts_pkg::ST_RECOVERING;
          last_result = cts_pkg::ST_RECOVERING;
        end else if (code[4] || (!ev.fd_frame && ev.payload_len > 7'd8)) begin
          o.status = cts_pkg::ST_BAD_LEN;
        end else begin
          o.dlc_code = code[3:0];
          if (ev.fifo_free == 6'd0) o.status = cts_pkg::ST_FIFO_FULL;
          else if (!ev.queue_accepted) o.status = cts_pkg::ST_REFUSED;
          else o.status = cts_pkg::ST_OK;
          last_result = o.status;
          if (o.status == cts_pkg::ST_OK) begin
            streak = 16'd0;
          end else begin
            fail_count = fail_count + 32'd1;
            if (streak != 16'hFFFF) streak = streak + 16'd1;
          end
        end
      end
      cts_pkg::OP_RX: begin
        hold_off = hold_base_ms;
        streak = 16'd0;
      end
      cts_pkg::OP_POLL: begin
        since = ev.now_ms - last_poll_ms;
        if (since >= {16'd0, poll_gap_ms}) begin
          last_poll_ms = ev.now_ms;
          if (recovering) begin
            clean = !ev.bus_off_flag && ev.activity != 2'd0 && !ev.passive_flag &&
                    !ev.warning_flag && ev.tx_err_cnt == 8'd0 && ev.rx_err_cnt == 7'd0;
            past = ev.now_ms - resume_at;
            if ((!recov_bus_off || clean) && !past[31]) begin
              recovering = 1'b0;
              recov_bus_off = 1'b0;
              resume_at = 32'd0;
              streak = 16'd0;
              last_result = cts_pkg::ST_OK;
              if (recov_count != 16'hFFFF) recov_count = recov_count + 16'd1;
              o.recovered = 1'b1;
            end
          end else if (ev.bus_off_flag) begin
            start_recovery(ev.now_ms, 1'b1);
            o.abort_pending = 1'b1;
            o.clear_init = 1'b1;
          end else if (ev.fifo_free == 6'd0 && streak >= {8'd0, fail_limit}) begin
            start_recovery(ev.now_ms, 1'b0);
            o.abort_pending = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
    o.tx_ready = !recovering;
    o.fail_streak = streak;
    o.recoveries = recov_count;
    o.hold_off_ms = hold_off;
    return o;
  endfunction

  function automatic event_t make_event(logic [1:0] op, logic [31:0] now, logic [6:0] len,
                                        logic fd, logic [5:0] fifo, logic acc, logic boff,
                                        logic [1:0] act, logic pas, logic wrn,
                                        logic [7:0] tec, logic [6:0] rec);
    event_t ev;
    ev.opcode = op;
    ev.now_ms = now;
    ev.payload_len = len;
    ev.fd_frame = fd;
    ev.fifo_free = fifo;
    ev.queue_accepted = acc;
    ev.bus_off_flag = boff;
    ev.activity = act;
    ev.passive_flag = pas;
    ev.warning_flag = wrn;
    ev.tx_err_cnt = tec;
    ev.rx_err_cnt = rec;
    return ev;
  endfunction

  function automatic event_t gen_event();
    event_t ev;
    int unsigned r;
    int unsigned k;
    r = $urandom_range(99);
    if (r < 45) ev.opcode = cts_pkg::OP_TX;
    else if (r < 55) ev.opcode = cts_pkg::OP_RX;
    else if (r < 95) ev.opcode = cts_pkg::OP_POLL;
    else ev.opcode = OP_UNUSED;
    r = $urandom_range(99);
    if (r < 3) ms_clock = $urandom();
    else if (r < 8) ms_clock = ms_clock + $urandom_range(70000);
    else ms_clock = ms_clock + $urandom_range(400);
    ev.now_ms = ms_clock;
    if ($urandom_range(99) < 60) begin
      k = $urandom_range(15);
      case (k)
        9:       ev.payload_len = 7'd12;
        10:      ev.payload_len = 7'd16;
        11:      ev.payload_len = 7'd20;
        12:      ev.payload_len = 7'd24;
        13:      ev.payload_len = 7'd32;
        14:      ev.payload_len = 7'd48;
        15:      ev.payload_len = 7'd64;
        default: ev.payload_len = 7'(k);
      endcase
    end else begin
      ev.payload_len = 7'($urandom_range(64));
    end
    ev.fd_frame = 1'($urandom_range(1));
    ev.fifo_free = ($urandom_range(99) < 40) ? 6'd0 : 6'($urandom_range(32, 1));
    ev.queue_accepted = ($urandom_range(99) < 75);
    ev.bus_off_flag = ($urandom_range(99) < 12);
    if ($urandom_range(1) == 0) begin
      ev.activity = 2'($urandom_range(3, 1));
      ev.passive_flag = 1'b0;
      ev.warning_flag = 1'b0;
      ev.tx_err_cnt = 8'd0;
      ev.rx_err_cnt = 7'd0;
    end else begin
      ev.activity = 2'($urandom_range(3));
      ev.passive_flag = 1'($urandom_range(1));
      ev.warning_flag = 1'($urandom_range(1));
      ev.tx_err_cnt = 8'($urandom_range(255));
      ev.rx_err_cnt = 7'($urandom_range(127));
    end
    return ev;
  endfunction

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      cts_pkg::REG_POLL_PERIOD: poll_gap_ms = val;
      cts_pkg::REG_FAIL_THRESH: fail_limit = val[7:0];
      cts_pkg::REG_BACKOFF_INI: hold_base_ms = val;
      default:                  hold_cap_ms = val;
    endcase
  endtask

  task automatic set_config(logic [15:0] period, logic [7:0] thresh, logic [15:0] ini,
                            logic [15:0] cap);
    write_reg(cts_pkg::REG_POLL_PERIOD, period);
    write_reg(cts_pkg::REG_FAIL_THRESH, {8'd0, thresh});
    write_reg(cts_pkg::REG_BACKOFF_INI, ini);
    write_reg(cts_pkg::REG_BACKOFF_MAX, cap);
    n_settings++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (pending_events.size() != 0 || req_ch.valid || expected_outcomes.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_random(int n, int unsigned src_pct, int unsigned snk_pct);
    src_idle_pct = src_pct;
    snk_stall_pct = snk_pct;
    repeat (n) pending_events.push_back(gen_event());
    wait_idle();
  endtask

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding", cycle_count,
               expected_outcomes.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        expected_outcomes.push_back(predict_outcome(offered));
        case (offered.opcode)
          cts_pkg::OP_TX:   n_tx++;
          cts_pkg::OP_RX:   n_rx++;
          cts_pkg::OP_POLL: n_poll++;
          default:          n_unused++;
        endcase
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_events.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          offered = pending_events.pop_front();
          req_ch.valid <= 1'b1;
          req_ch.opcode <= offered.opcode;
          req_ch.now_ms <= offered.now_ms;
          req_ch.payload_len <= offered.payload_len;
          req_ch.fd_frame <= offered.fd_frame;
          req_ch.fifo_free <= offered.fifo_free;
          req_ch.queue_accepted <= offered.queue_accepted;
          req_ch.bus_off_flag <= offered.bus_off_flag;
          req_ch.activity <= offered.activity;
          req_ch.passive_flag <= offered.passive_flag;
          req_ch.warning_flag <= offered.warning_flag;
          req_ch.tx_err_cnt <= offered.tx_err_cnt;
          req_ch.rx_err_cnt <= offered.rx_err_cnt;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.status = rsp_ch.status;
        got.dlc_code = rsp_ch.dlc_code;
        got.recovered = rsp_ch.recovered;
        got.abort_pending = rsp_ch.abort_pending;
        got.clear_init = rsp_ch.clear_init;
        got.tx_ready = rsp_ch.tx_ready;
        got.fail_streak = rsp_ch.fail_streak;
        got.recoveries = rsp_ch.recoveries;
        got.hold_off_ms = rsp_ch.hold_off_ms;
        if (got.abort_pending === 1'b1) n_started++;
        if (got.recovered === 1'b1) n_finished++;
        if (expected_outcomes.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("Result with no pending item: %p", got);
        end else begin
          want = expected_outcomes.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("Mismatch at cycle %0d (expected/actual):", cycle_count);
              $display("  status %0d/%0d dlc %0d/%0d recovered %b/%b abort %b/%b init %b/%b",
                       want.status, got.status, want.dlc_code, got.dlc_code,
                       want.recovered, got.recovered, want.abort_pending,
                       got.abort_pending, want.clear_init, got.clear_init);
              $display("  tx_ready %b/%b streak %0d/%0d recoveries %0d/%0d hold_off %0d/%0d",
                       want.tx_ready, got.tx_ready, want.fail_streak, got.fail_streak,
                       want.recoveries, got.recoveries, want.hold_off_ms, got.hold_off_ms);
            end
          end
        end
      end
      rsp_ch.ready <= !holding && ($urandom_range(99) >= snk_stall_pct);
    end
  end

  initial begin
    holding = 1'b0;
    wait (hold_go);
    @(posedge clk);
    holding <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    holding <= 1'b0;
  end

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = 2'd0;
    cfg_data = 16'd0;
    req_ch.valid = 1'b0;
    req_ch.opcode = cts_pkg::OP_TX;
    req_ch.now_ms = 32'd0;
    req_ch.payload_len = 7'd0;
    req_ch.fd_frame = 1'b0;
    req_ch.fifo_free = 6'd0;
    req_ch.queue_accepted = 1'b0;
    req_ch.bus_off_flag = 1'b0;
    req_ch.activity = 2'd0;
    req_ch.passive_flag = 1'b0;
    req_ch.warning_flag = 1'b0;
    req_ch.tx_err_cnt = 8'd0;
    req_ch.rx_err_cnt = 7'd0;
    rsp_ch.ready = 1'b0;
    hold_go = 1'b0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    ms_clock = 32'd0;
    cycle_count = 0;
    mismatches = 0;
    n_tx = 0;
    n_rx = 0;
    n_poll = 0;
    n_unused = 0;
    n_started = 0;
    n_finished = 0;
    n_settings = 1;

    poll_gap_ms = cts_pkg::POLL_PERIOD_RST;
    fail_limit = cts_pkg::FAIL_THRESH_RST;
    hold_base_ms = cts_pkg::BACKOFF_INI_RST;
    hold_cap_ms = cts_pkg::BACKOFF_MAX_RST;
    streak = 16'd0;
    fail_count = 32'd0;
    recov_count = 16'd0;
    recovering = 1'b0;
    recov_bus_off = 1'b0;
    resume_at = 32'd0;
    hold_off = cts_pkg::BACKOFF_INI_RST;
    last_poll_ms = 32'd0;
    last_result = cts_pkg::ST_OK;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed sequence at reset settings.
    pending_events.push_back(make_event(cts_pkg::OP_TX, 0, 0, 0, 1, 1, 0, 0, 0, 0, 0, 0));
    pending_events.push_back(make_event(cts_pkg::OP_TX, 0, 64, 1, 1, 1, 0, 0, 0, 0, 0, 0));
    pending_events.push_back(make_event(cts_pkg::OP_TX, 0, 12, 0, 1, 1, 0, 0, 0, 0, 0, 0));
    pending_events.push_back(make_event(cts_pkg::OP_TX, 0, 13, 1, 1, 1, 0, 0, 0, 0, 0, 0));
    pending_events.push_back(make_event(cts_pkg::OP_TX, 0, 8, 0, 0, 1, 0, 0, 0, 0, 0, 0));
    pending_events.push_back(make_event(cts_pkg::OP_TX, 0, 48, 1, 32, 0, 0, 0, 0, 0, 0, 0));
    pending_events.push_back(make_event(cts_pkg::OP_TX, 0, 3, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_events.push_back(make_event(OP_UNUSED, 32'hFFFF_FFFF, 7'd64, 1, 32, 1, 1, 3,
                                        1, 1, 255, 127));
    pending_events.push_back(make_event(cts_pkg::OP_POLL, 3, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    pending_events.push_back(make_event(cts_pkg::OP_POLL, 10, 0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
    pending_events.push_back(make_event(cts_pkg::OP_TX, 20, 8, 0, 4, 1, 0, 0, 0, 0, 0, 0));
    pending_events.push_back(make_event(cts_pkg::OP_POLL, 100, 0, 0, 4, 0, 0, 1,
                                        0, 0, 0, 0));
    pending_events.push_back(make_event(cts_pkg::OP_POLL, 300, 0, 0, 4, 0, 0, 1,
                                        0, 0, 0, 0));
    pending_events.push_back(make_event(cts_pkg::OP_POLL, 400, 0, 0, 4, 0, 1, 2,
                                        1, 1, 9, 9));
    pending_events.push_back(make_event(cts_pkg::OP_POLL, 1000, 0, 0, 4, 0, 0, 1,
                                        0, 0, 5, 0));
    pending_events.push_back(make_event(cts_pkg::OP_POLL, 1010, 0, 0, 4, 0, 0, 0,
                                        0, 0, 0, 0));
    pending_events.push_back(make_event(cts_pkg::OP_POLL, 1020, 0, 0, 4, 0, 0, 3,
                                        0, 0, 0, 0));
    pending_events.push_back(make_event(cts_pkg::OP_RX, 1030, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_events.push_back(make_event(cts_pkg::OP_POLL, 32'hFFFF_FFF0, 0, 0, 8, 0, 1, 1,
                                        0, 0, 0, 0));
    pending_events.push_back(make_event(cts_pkg::OP_POLL, 32'h0000_0050, 0, 0, 8, 0, 0, 1,
                                        0, 0, 0, 0));
    pending_events.push_back(make_event(cts_pkg::OP_POLL, 32'h0000_0100, 0, 0, 8, 0, 0, 1,
                                        0, 0, 0, 0));
    pending_events.push_back(make_event(cts_pkg::OP_TX, 0, 20, 1, 5, 1, 0, 0, 0, 0, 0, 0));
    pending_events.push_back(make_event(cts_pkg::OP_POLL, 32'hFFFF_FFFF, 7'd64, 1, 32, 1,
                                        1, 3, 1, 1, 255, 127));
    pending_events.push_back(make_event(cts_pkg::OP_RX, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    wait_idle();

    run_random(250, 0, 0);

    set_config(16'd0, 8'd1, 16'd1, 16'd65535);
    run_random(250, 50, 0);

    set_config(16'd65535, 8'd255, 16'd65535, 16'd1);
    run_random(100, 0, 50);

    // The sink holds off for a long stretch while the source keeps offering.
    set_config(16'd20, 8'd2, 16'd100, 16'd800);
    hold_go = 1'b1;
    run_random(250, 37, 37);

    // A zero threshold; the source pauses after each chunk until all results are in.
    set_config(16'd5, 8'd0, 16'd250, 16'd4000);
    for (int c = 0; c < 6; c++) begin
      case (c % 3)
        0:       run_random(50, 0, 0);
        1:       run_random(50, 50, 50);
        default: run_random(50, 37, 0);
      endcase
    end

    repeat (5) @(posedge clk);
    mismatches = mismatches + expected_outcomes.size();
    $display("Ran %0d transmit, %0d received, %0d poll and %0d unused events", n_tx, n_rx,
             n_poll, n_unused);
    $display("Saw %0d recoveries started and %0d finished over %0d register settings",
             n_started, n_finished, n_settings);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
design/cts_pkg.sv
design/cts_if.sv
design/cts_front.sv
design/cts_queue.sv
design/cts_back.sv
design/can_tx_recovery_supervisor.sv
sim/can_tx_recovery_supervisor_tb.sv
